>>> src/kabf_pkg.sv
// Shared types and operation codes for the angle/bias Kalman filter.
// No dependencies.
`default_nettype none
package kabf_pkg;
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_t;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_Q = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_Q  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MEAS_R  = 2'd2;
endpackage
`default_nettype wire

>>> src/kabf_if.sv
// Valid/ready channel interface carrying a parameterized payload.
// Depends on nothing.
`default_nettype none
interface kabf_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/kalman_angle_bias_filter.sv
// Two-state Kalman filter (angle and gyro bias), top level.
// Uses kabf_pkg and kabf_if.
//
// Input item: {time_step, measured_rate, measured_angle} on in_ch.data,
// measured_angle in the low WORD_WIDTH bits. One result item per input:
// filtered_angle on out_ch.data.
// Configuration: cfg_we/cfg_idx/cfg_data writes angle process noise (0),
// bias process noise (1), measurement noise (2); write only while idle.
// A sequencer walks 24 steps: twelve arithmetic operations (ten multiplies
// and two divides), each followed by a step that folds its result into the
// state. Every product and quotient is made by one shared
// shift-add/restoring-divide unit that handles one bit per cycle. An
// operation costs a load step, the serial pass through the unit and a
// write-back step. After the last write-back the result is registered
// in out_r and shown on out_ch; no new item is taken before it leaves.
// Reset clears the state estimates and covariance and loads the default
// noise settings. A stalled receiver holds the result in the output
// register; the next item is taken once that result leaves.
`default_nettype none
module kalman_angle_bias_filter #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  kabf_if.sink      in_ch,
  kabf_if.source    out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [kabf_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire logic [WORD_WIDTH-2:0]          cfg_data
);
  import kabf_pkg::*;
  localparam int W  = WORD_WIDTH;
  localparam int MW = 2 * W + FRAC_BITS + 2;
  localparam int DN = W + FRAC_BITS;
  localparam int CW = $clog2(DN + 2);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_SEQ, S_ARITH, S_OUT} st_t;

  // saturating add/sub in W bits
  function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
    if (v > $signed({WMAX[W-1], WMAX})) return WMAX;
    if (v < $signed({WMIN[W-1], WMIN})) return WMIN;
    return v[W-1:0];
  endfunction

  // sign-extend one word by a bit
  function automatic logic signed [W:0] sx(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  st_t st_r;
  logic [5:0] pc_r;
  logic signed [W-1:0] ang_r, bias_r, p0_r, p1_r, p2_r, p3_r;
  logic signed [W-1:0] ma_r, rate_r, dt_r, t_r, dp_r, s_r, k0_r, k1_r;
  logic signed [W-1:0] y_r, q00_r, q01_r, res_r, out_r;
  logic [W-2:0] qa_r, qb_r, qr_r;

  // shared bit-serial unit
  op_t op_r;
  logic neg_r;
  logic [W-1:0] ma_mag_r;           // multiplicand / divisor magnitude
  logic [DN-1:0] sh_r;              // multiplier bits or dividend bits
  logic [MW-1:0] acc_r;             // product accumulator
  logic [W:0] rem_r;
  logic [DN-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic zdiv_r;
  logic znum_r;

  logic signed [W-1:0] opa, opb;
  op_t opk;
  logic [W:0] rem_sh;
  logic [W-1:0] amag, bmag;
  logic signed [W-1:0] ares;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // Operation list: odd entries load an arithmetic op, result in res_r.
  always_comb begin
    opa = dt_r; opb = rate_r; opk = OP_MUL;
    unique case (pc_r)
      6'd1:  begin opa = dt_r; opb = rate_r; end
      6'd3:  begin opa = dt_r; opb = p3_r; end
      6'd5:  begin opa = dt_r; opb = t_r; end
      6'd7:  begin opa = $signed({1'b0, qb_r}); opb = dt_r; end
      6'd9:  begin opa = p0_r; opb = s_r; opk = OP_DIV; end
      6'd11: begin opa = p2_r; opb = s_r; opk = OP_DIV; end
      6'd13: begin opa = k0_r; opb = y_r; end
      6'd15: begin opa = k1_r; opb = y_r; end
      6'd17: begin opa = k0_r; opb = q00_r; end
      6'd19: begin opa = k0_r; opb = q01_r; end
      6'd21: begin opa = k1_r; opb = q00_r; end
      6'd23: begin opa = k1_r; opb = q01_r; end
      default: ;
    endcase
  end

  assign amag = mag(opa);
  assign bmag = mag(opb);
  assign rem_sh = {rem_r[W-1:0], sh_r[DN-1]};

  // final saturation of product/quotient magnitude
  always_comb begin
    logic [MW-1:0] m;
    m = (op_r == OP_MUL) ? (acc_r >> FRAC_BITS) : MW'(quo_r);
    if (op_r == OP_DIV && zdiv_r) ares = znum_r ? '0 : (neg_r ? WMIN : WMAX);
    else if (m > MW'(WMAX)) ares = neg_r ? WMIN : WMAX;
    else ares = neg_r ? W'(-$signed(m[W-1:0])) : m[W-1:0];
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pc_r <= '0;
      ang_r <= '0; bias_r <= '0; p0_r <= '0; p1_r <= '0; p2_r <= '0; p3_r <= '0;
      qa_r <= (W-1)'(66); qb_r <= (W-1)'(197); qr_r <= (W-1)'(1966);
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ANGLE_Q: qa_r <= cfg_data;
          CFG_BIAS_Q:  qb_r <= cfg_data;
          CFG_MEAS_R:  qr_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: if (in_ch.valid) begin
          ma_r   <= in_ch.data[W-1:0];
          dt_r   <= $signed({1'b0, in_ch.data[3*W-2:2*W]});
          rate_r <= sat($signed({in_ch.data[2*W-1], in_ch.data[2*W-1:W]})
                        - $signed({bias_r[W-1], bias_r}));
          pc_r <= 6'd1;
          st_r <= S_SEQ;
        end
        S_SEQ: begin
          pc_r <= pc_r + 6'd1;
          if (pc_r[0]) begin
            // load the serial unit
            op_r <= opk; neg_r <= opa[W-1] ^ opb[W-1];
            zdiv_r <= (opb == '0);
            znum_r <= (opa == '0);
            acc_r <= '0; rem_r <= '0; quo_r <= '0;
            if (opk == OP_MUL) begin
              ma_mag_r <= amag; sh_r <= DN'(bmag);
              cnt_r <= CW'(W);
            end else begin
              ma_mag_r <= bmag; sh_r <= {amag, {FRAC_BITS{1'b0}}};
              cnt_r <= CW'(DN);
            end
            st_r <= S_ARITH;
          end else begin
            // consume res_r of the previous op
            unique case (pc_r)
              6'd2: ang_r <= sat({ang_r[W-1], ang_r} + {res_r[W-1], res_r});
              6'd4: begin
                dp_r <= res_r;
                t_r <= sat(sx(sat(sx(sat(sx(res_r) - sx(p1_r))) - sx(p2_r)))
                           + $signed({2'b00, qa_r}));
              end
              6'd6: begin
                p0_r <= sat({p0_r[W-1], p0_r} + {res_r[W-1], res_r});
                p1_r <= sat({p1_r[W-1], p1_r} - {dp_r[W-1], dp_r});
                p2_r <= sat({p2_r[W-1], p2_r} - {dp_r[W-1], dp_r});
              end
              6'd8: begin
                p3_r <= sat({p3_r[W-1], p3_r} + {res_r[W-1], res_r});
                s_r <= sat({p0_r[W-1], p0_r} + {1'b0, qr_r});
              end
              6'd10: k0_r <= res_r;
              6'd12: begin
                k1_r <= res_r;
                y_r <= sat({ma_r[W-1], ma_r} - {ang_r[W-1], ang_r});
              end
              6'd14: ang_r <= sat({ang_r[W-1], ang_r} + {res_r[W-1], res_r});
              6'd16: begin
                bias_r <= sat({bias_r[W-1], bias_r} + {res_r[W-1], res_r});
                q00_r <= p0_r; q01_r <= p1_r;
              end
              6'd18: p0_r <= sat({p0_r[W-1], p0_r} - {res_r[W-1], res_r});
              6'd20: p1_r <= sat({p1_r[W-1], p1_r} - {res_r[W-1], res_r});
              6'd22: p2_r <= sat({p2_r[W-1], p2_r} - {res_r[W-1], res_r});
              6'd24: begin
                p3_r <= sat({p3_r[W-1], p3_r} - {res_r[W-1], res_r});
                out_r <= ang_r;
                st_r <= S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_ARITH: begin
          if (cnt_r == '0) begin
            res_r <= ares;
            st_r <= S_SEQ;
          end else begin
            cnt_r <= cnt_r - 1'b1;
            if (op_r == OP_MUL) begin
              // shift-add: add multiplicand at bit position W-cnt
              if (sh_r[0])
                acc_r <= acc_r + (MW'(ma_mag_r) << (W - int'(cnt_r)));
              sh_r <= sh_r >> 1;
            end else begin
              sh_r <= sh_r << 1;
              if (rem_sh >= {1'b0, ma_mag_r}) begin
                rem_r <= rem_sh - {1'b0, ma_mag_r};
                quo_r <= {quo_r[DN-2:0], 1'b1};
              end else begin
                rem_r <= rem_sh;
                quo_r <= {quo_r[DN-2:0], 1'b0};
              end
            end
          end
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready)
    else $error("input taken while busy");
  a_seq_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(pc_r) == 6'd24)
    else $error("result shown before sequence end");
endmodule
`default_nettype wire
